// ----- design/usc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the month-length table for the Unix time converter.
// Used by the microcode ROM, the sequencer and the datapath; no dependencies.
package usc_pkg;

    localparam int IN_W     = 32;
    localparam int OUT_W    = 48;
    localparam int PC_W     = 4;
    localparam int DAYS_W   = 16;
    localparam int YEAR_W   = 12;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
    localparam logic [YEAR_W-1:0] NONLEAP_CENTURY = 12'd2100;
    localparam logic [IN_W-1:0]   EPOCH_WDAY_OFS  = 32'd3;

    // Reciprocals: quotient is the product shifted right by 37, 36 and 32
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_7  = 32'h2492_4925;

    // Operation codes
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_WAIT  = 4'd1;
    localparam logic [3:0] OP_DIV   = 4'd2;
    localparam logic [3:0] OP_PUT   = 4'd3;
    localparam logic [3:0] OP_WPREP = 4'd4;
    localparam logic [3:0] OP_YINIT = 4'd5;
    localparam logic [3:0] OP_YEAR  = 4'd6;
    localparam logic [3:0] OP_MONTH = 4'd7;
    localparam logic [3:0] OP_OUT   = 4'd8;

    // Divisor select
    localparam logic [1:0] DV_60 = 2'd0;
    localparam logic [1:0] DV_24 = 2'd1;
    localparam logic [1:0] DV_7  = 2'd2;

    // Destination select
    localparam logic [1:0] DST_SEC  = 2'd0;
    localparam logic [1:0] DST_MIN  = 2'd1;
    localparam logic [1:0] DST_HOUR = 2'd2;
    localparam logic [1:0] DST_WDAY = 2'd3;

    // Jump kinds
    localparam logic [1:0] JMP_NONE   = 2'd0;
    localparam logic [1:0] JMP_LOOP   = 2'd1;
    localparam logic [1:0] JMP_ALWAYS = 2'd2;

    typedef struct packed {
        logic [3:0]      op;
        logic [1:0]      arg;
        logic [1:0]      jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic loop;
        logic stall;
    } t_stat;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        begin
            unique case (month)
                4'd1:                      len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ----- design/unix_seconds_to_calendar_date.sv -----
`timescale 1ns / 1ps
// Unix seconds to calendar date converter: top level.
// Instantiates usc_ucode_rom, usc_sequencer and usc_datapath; depends on usc_pkg.
//
// Usage:
//   Slave channel takes one 32-bit count of seconds since 1970-01-01 00:00:00 per
//   transaction. Master channel returns one transaction per input with second, minute,
//   hour, weekday (1 = Monday), day, month and full year.
//   One item is in work at a time. s_axis_tready is high only while the program
//   waits at its first step. A transaction runs from acceptance to the result register
//   through four divisions (by 60, 60, 24 and 7) by reciprocal multiplication on one
//   shared multiplier, two steps each, the year and month subtract loops, and a few
//   steps of bookkeeping. The next input is taken at the earliest in the cycle after
//   the result is registered.
//   The result sits in an output register; the next input is taken while it waits.
//   If the receiver stalls, the program holds at its last step until the register
//   frees, then returns to wait for input.
//   Reset clears the step counter and the output valid; the first input may
//   arrive on the cycle after reset is released.
module unix_seconds_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // unix_seconds[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // second_of_minute[5:0], minute_of_hour[11:6], hour_of_day[16:12], weekday[19:17],
    // day_of_month[24:20], month_of_year[28:25], full_year[40:29], zero[47:41]
    output logic [47:0] m_axis_tdata
);

    logic [usc_pkg::PC_W-1:0] pc;
    usc_pkg::t_uword          uword;
    usc_pkg::t_stat           stat;

    usc_ucode_rom u_rom (
        .i_pc    (pc),
        .o_uword (uword)
    );

    usc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uword (uword),
        .i_stat  (stat),
        .o_pc    (pc)
    );

    usc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uword       (uword),
        .o_stat        (stat),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- design/usc_ucode_rom.sv -----
`timescale 1ns / 1ps
// Microcode ROM: one control word per program step of the converter.
// Depends on usc_pkg.
module usc_ucode_rom (
    input  logic [usc_pkg::PC_W-1:0] i_pc,
    output usc_pkg::t_uword          o_uword
);

    always_comb begin
        unique case (i_pc)
            4'd0:  o_uword = '{usc_pkg::OP_WAIT,  2'd0,              usc_pkg::JMP_NONE,   4'd0};
            4'd1:  o_uword = '{usc_pkg::OP_DIV,   usc_pkg::DV_60,    usc_pkg::JMP_NONE,   4'd0};
            4'd2:  o_uword = '{usc_pkg::OP_PUT,   usc_pkg::DST_SEC,  usc_pkg::JMP_NONE,   4'd0};
            4'd3:  o_uword = '{usc_pkg::OP_DIV,   usc_pkg::DV_60,    usc_pkg::JMP_NONE,   4'd0};
            4'd4:  o_uword = '{usc_pkg::OP_PUT,   usc_pkg::DST_MIN,  usc_pkg::JMP_NONE,   4'd0};
            4'd5:  o_uword = '{usc_pkg::OP_DIV,   usc_pkg::DV_24,    usc_pkg::JMP_NONE,   4'd0};
            4'd6:  o_uword = '{usc_pkg::OP_PUT,   usc_pkg::DST_HOUR, usc_pkg::JMP_NONE,   4'd0};
            4'd7:  o_uword = '{usc_pkg::OP_WPREP, 2'd0,              usc_pkg::JMP_NONE,   4'd0};
            4'd8:  o_uword = '{usc_pkg::OP_DIV,   usc_pkg::DV_7,     usc_pkg::JMP_NONE,   4'd0};
            4'd9:  o_uword = '{usc_pkg::OP_PUT,   usc_pkg::DST_WDAY, usc_pkg::JMP_NONE,   4'd0};
            4'd10: o_uword = '{usc_pkg::OP_YINIT, 2'd0,              usc_pkg::JMP_NONE,   4'd0};
            4'd11: o_uword = '{usc_pkg::OP_YEAR,  2'd0,              usc_pkg::JMP_LOOP,   4'd11};
            4'd12: o_uword = '{usc_pkg::OP_MONTH, 2'd0,              usc_pkg::JMP_LOOP,   4'd12};
            4'd13: o_uword = '{usc_pkg::OP_OUT,   2'd0,              usc_pkg::JMP_ALWAYS, 4'd0};
            default: o_uword = '{usc_pkg::OP_NOP, 2'd0,              usc_pkg::JMP_ALWAYS, 4'd0};
        endcase
    end

endmodule

// ----- design/usc_sequencer.sv -----
`timescale 1ns / 1ps
// Step counter of the microcoded converter: holds, advances or jumps per control word.
// Depends on usc_pkg.
module usc_sequencer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  usc_pkg::t_uword          i_uword,
    input  usc_pkg::t_stat           i_stat,
    output logic [usc_pkg::PC_W-1:0] o_pc
);

    logic [usc_pkg::PC_W-1:0] r_pc;
    logic [usc_pkg::PC_W-1:0] n_pc;

    always_comb begin
        priority if (i_stat.stall) begin
            n_pc = r_pc;
        end else if (i_uword.jmp == usc_pkg::JMP_ALWAYS) begin
            n_pc = i_uword.target;
        end else if (i_uword.jmp == usc_pkg::JMP_LOOP && i_stat.loop) begin
            n_pc = i_uword.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_pc = r_pc;

endmodule

// ----- design/usc_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the converter: reciprocal-multiply divider, year and month subtractors,
// result register. Depends on usc_pkg; driven by control words from usc_ucode_rom.
module usc_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  usc_pkg::t_uword           i_uword,
    output usc_pkg::t_stat            o_stat,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [usc_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [usc_pkg::OUT_W-1:0] m_axis_tdata
);

    logic [31:0]                  r_acc, n_acc;
    logic [31:0]                  r_quo, n_quo;
    logic [usc_pkg::DAYS_W-1:0]   r_days, n_days;
    logic [5:0]                   r_sec, n_sec;
    logic [5:0]                   r_min, n_min;
    logic [4:0]                   r_hour, n_hour;
    logic [2:0]                   r_wday, n_wday;
    logic [usc_pkg::YEAR_W-1:0]   r_year, n_year;
    logic [3:0]                   r_month, n_month;
    logic                         r_out_valid, n_out_valid;
    logic [usc_pkg::OUT_W-1:0]    r_out_data, n_out_data;

    logic [31:0] recip;
    logic [63:0] prod;
    logic [31:0] quo;
    logic [5:0]  divisor;
    logic [5:0]  rem;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        year_ge;
    logic        month_ge;
    logic        out_busy;

    assign prod     = 64'(r_acc) * 64'(recip);
    assign rem      = r_acc[5:0] - 6'(r_quo[5:0] * divisor);
    assign leap     = (r_year[1:0] == 2'b00) && (r_year != usc_pkg::NONLEAP_CENTURY);
    assign ylen     = leap ? 9'd366 : 9'd365;
    assign mlen     = usc_pkg::month_len(leap, r_month);
    assign year_ge  = (r_acc >= {23'd0, ylen});
    assign month_ge = (r_acc >= {27'd0, mlen});
    assign out_busy = r_out_valid && !m_axis_tready;

    always_comb begin
        unique case (i_uword.arg)
            usc_pkg::DV_24: recip = usc_pkg::RECIP_24;
            usc_pkg::DV_7:  recip = usc_pkg::RECIP_7;
            default:        recip = usc_pkg::RECIP_60;
        endcase
    end

    always_comb begin
        unique case (i_uword.arg)
            usc_pkg::DV_24: quo = {4'd0, prod[63:36]};
            usc_pkg::DV_7:  quo = prod[63:32];
            default:        quo = {5'd0, prod[63:37]};
        endcase
    end

    always_comb begin
        unique case (i_uword.arg)
            usc_pkg::DST_HOUR: divisor = 6'd24;
            usc_pkg::DST_WDAY: divisor = 6'd7;
            default:           divisor = 6'd60;
        endcase
    end

    always_comb begin
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_days      = r_days;
        n_sec       = r_sec;
        n_min       = r_min;
        n_hour      = r_hour;
        n_wday      = r_wday;
        n_year      = r_year;
        n_month     = r_month;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        o_stat      = '{loop: 1'b0, stall: 1'b0};
        s_axis_tready = 1'b0;

        unique case (i_uword.op)
            usc_pkg::OP_WAIT: begin
                s_axis_tready = 1'b1;
                o_stat.stall  = !s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_acc = s_axis_tdata;
                end
            end
            usc_pkg::OP_DIV: begin
                n_quo = quo;
            end
            usc_pkg::OP_PUT: begin
                n_acc = r_quo;
                unique case (i_uword.arg)
                    usc_pkg::DST_SEC:  n_sec  = rem;
                    usc_pkg::DST_MIN:  n_min  = rem;
                    usc_pkg::DST_HOUR: n_hour = rem[4:0];
                    default:           n_wday = rem[2:0] + 3'd1;
                endcase
            end
            usc_pkg::OP_WPREP: begin
                n_days = r_acc[usc_pkg::DAYS_W-1:0];
                n_acc  = r_acc + usc_pkg::EPOCH_WDAY_OFS;
            end
            usc_pkg::OP_YINIT: begin
                n_acc  = {16'd0, r_days};
                n_year = usc_pkg::EPOCH_YEAR;
            end
            usc_pkg::OP_YEAR: begin
                o_stat.loop = year_ge;
                if (year_ge) begin
                    n_acc  = r_acc - {23'd0, ylen};
                    n_year = r_year + 1'b1;
                end else begin
                    n_month = '0;
                end
            end
            usc_pkg::OP_MONTH: begin
                o_stat.loop = month_ge && (r_month != 4'd11);
                if (month_ge && (r_month != 4'd11)) begin
                    n_acc   = r_acc - {27'd0, mlen};
                    n_month = r_month + 1'b1;
                end
            end
            usc_pkg::OP_OUT: begin
                o_stat.stall = out_busy;
                if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_year, r_month + 4'd1, r_acc[4:0] + 5'd1,
                                   r_wday, r_hour, r_min, r_sec};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_quo      <= n_quo;
        r_days     <= n_days;
        r_sec      <= n_sec;
        r_min      <= n_min;
        r_hour     <= n_hour;
        r_wday     <= n_wday;
        r_year     <= n_year;
        r_month    <= n_month;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- design/usc_checker.sv -----
`timescale 1ns / 1ps
// Port checker for the Unix time converter, bound to the top level.
// Depends only on the top-level ports.
module usc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:0] < 6'd60 && m_axis_tdata[11:6] < 6'd60
            && m_axis_tdata[16:12] < 5'd24 && m_axis_tdata[19:17] != 3'd0
            && m_axis_tdata[24:20] != 5'd0 && m_axis_tdata[28:25] != 4'd0
            && m_axis_tdata[28:25] < 4'd13 && m_axis_tdata[40:29] >= 12'd1970
            && m_axis_tdata[40:29] <= 12'd2106 && m_axis_tdata[47:41] == 7'd0)
        else $error("result field out of range");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a transaction is in work");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind unix_seconds_to_calendar_date usc_checker u_chk (.*);

// ----- tb/sv/unix_seconds_to_calendar_date_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for unix_seconds_to_calendar_date: drives second counts on the
// input stream and compares each result with a calendar breakdown computed here.
// Depends only on the block under test; reads no files.
module unix_seconds_to_calendar_date_test;

    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 300;

    // Result transaction layout, lowest bits last.
    typedef struct packed {
        logic [6:0]  pad;
        logic [11:0] full_year;
        logic [3:0]  month_of_year;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
    } t_calendar;

    class calendar_scoreboard;
        t_calendar expected_dates[$];
        int        errors = 0;

        function bit leap_year(int unsigned yr);
            return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        endfunction

        function t_calendar to_calendar(logic [31:0] secs);
            t_calendar   date;
            int unsigned t;
            int unsigned days;
            int unsigned yr;
            int unsigned mo;
            int unsigned ylen;
            int unsigned mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            t = secs;
            date = '0;
            date.second_of_minute = 6'(t % 60);
            t = t / 60;
            date.minute_of_hour = 6'(t % 60);
            t = t / 60;
            date.hour_of_day = 5'(t % 24);
            days = t / 24;
            // Day zero was a Thursday.
            date.weekday = 3'((days + 3) % 7 + 1);
            yr = 1970;
            forever begin
                ylen = leap_year(yr) ? 366 : 365;
                if (days < ylen) break;
                days -= ylen;
                yr++;
            end
            if (leap_year(yr)) mlen[1] = 29;
            mo = 0;
            while (mo < 11 && days >= mlen[mo]) begin
                days -= mlen[mo];
                mo++;
            end
            date.day_of_month = 5'(days + 1);
            date.month_of_year = 4'(mo + 1);
            date.full_year = 12'(yr);
            return date;
        endfunction

        function void note_seconds(logic [31:0] secs);
            expected_dates.push_back(to_calendar(secs));
        endfunction

        function void compare(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_date(logic [47:0] data);
            t_calendar got;
            t_calendar want;
            got = data;
            if (expected_dates.size() == 0) begin
                $error("result with no pending input: tdata=%h", data);
                errors++;
                return;
            end
            want = expected_dates.pop_front();
            compare("second_of_minute", 12'(want.second_of_minute),
                    12'(got.second_of_minute));
            compare("minute_of_hour", 12'(want.minute_of_hour), 12'(got.minute_of_hour));
            compare("hour_of_day", 12'(want.hour_of_day), 12'(got.hour_of_day));
            compare("weekday", 12'(want.weekday), 12'(got.weekday));
            compare("day_of_month", 12'(want.day_of_month), 12'(got.day_of_month));
            compare("month_of_year", 12'(want.month_of_year), 12'(got.month_of_year));
            compare("full_year", want.full_year, got.full_year);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // unix_seconds[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // second_of_minute[5:0], minute_of_hour[11:6], hour_of_day[16:12], weekday[19:17],
    // day_of_month[24:20], month_of_year[28:25], full_year[40:29], zero[47:41]
    logic [47:0] m_axis_tdata;

    calendar_scoreboard dates = new();
    int          send_idle_pct;
    int          recv_idle_pct;
    int unsigned cycles = 0;

    unix_seconds_to_calendar_date u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) dates.note_seconds(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) dates.check_date(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("unix_seconds_to_calendar_date: mismatch");
            $finish;
        end
    end

    // Hold the transaction until it is accepted; valid stays high until the next call.
    task automatic send_seconds(logic [31:0] secs);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (dates.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] directed[$];
        int unsigned day_num;
        int unsigned secs;
        int          mode;
        directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                     32'd86400, 32'd31535999, 32'd68169600, 32'd94694399,
                     32'd951782400, 32'd951868799, 32'd951868800, 32'd978307199,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'd4107542399, 32'd4107542400,
                     32'd4233686400, 32'd4260211199, 32'd4291747200, 32'hFFFF_FFFF,
                     32'hAAAA_AAAA, 32'h5555_5555};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_idle_pct = 29;
        recv_idle_pct = 57;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_seconds(directed[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 57;
                recv_idle_pct = 29;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            mode = $urandom_range(3);
            if (mode == 2) begin
                // Land on or just before a midnight to stress day, month and year rollover.
                day_num = $urandom_range(49710, 1);
                secs = day_num * 86400 - $urandom_range(1, 0);
            end else if (mode == 3) begin
                secs = $urandom_range(32'h0010_0000, 0);
            end else begin
                secs = $urandom();
            end
            send_seconds(secs);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (dates.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (dates.errors == 0) begin
            $display("unix_seconds_to_calendar_date: match");
        end else begin
            $display("unix_seconds_to_calendar_date: mismatch");
        end
        $finish;
    end

endmodule
